@@ hw/rtl/sts_pkg.sv @@
// Shared types, codes and constants for the S-expression token scanner.
package sts_pkg;

  // Default parameter values
  localparam int MAX_DEPTH_DEF     = 32;
  localparam int POSITION_BITS_DEF = 24;

  // Result field widths
  localparam int KIND_W  = 3;
  localparam int ERR_W   = 3;
  localparam int POS_W   = 24;
  localparam int LEN_W   = 24;
  localparam int DEPTH_W = 6;

  // Result queue geometry
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Input actions
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Lexer modes
  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_PLAIN   = 2'd2;
  localparam logic [1:0] MODE_QUOTED  = 2'd3;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_OPEN  = 3'd0;
  localparam logic [KIND_W-1:0] EV_CLOSE = 3'd1;
  localparam logic [KIND_W-1:0] EV_ATOM  = 3'd2;
  localparam logic [KIND_W-1:0] EV_DONE  = 3'd3;
  localparam logic [KIND_W-1:0] EV_ERROR = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_DEEP    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SECOND_TOP  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_STRAY_CLOSE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOP_ATOM    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OPEN_QUOTE  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_QUOTE_ATOM  = 3'd6;
  localparam logic [ERR_W-1:0] ERR_MISS_CLOSE  = 3'd7;

  // Characters
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [ERR_W-1:0]   error_code;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   atom_length;
    logic               is_quoted;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } result_t;

  // Results produced by one accepted input item
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

  // Whitespace: space, TAB, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

@@ hw/rtl/sts_lexer.sv @@
// Lexer state and event generation for one input byte per cycle, on cycles that fire.
module sts_lexer #(
  parameter int MAX_DEPTH     = sts_pkg::MAX_DEPTH_DEF,
  parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          action,
  input  logic [7:0]    data_byte,
  output sts_pkg::push_t push
);

  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int PB  = POSITION_BITS;
  localparam int PXW = PB + sts_pkg::POS_W;
  localparam int DXW = DW + sts_pkg::DEPTH_W;

  logic [1:0]    mode_r, mode_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] start_r, start_nxt;
  logic          top_r, top_nxt;
  logic          err_r, err_nxt;

  // Widened views for output formatting
  logic [PB-1:0]  len_plain, len_quoted;
  logic [PXW-1:0] pos_x, start_x, lenp_x, lenq_x;
  logic [DXW-1:0] dcur_x, dinc_x, ddec_x;
  logic [sts_pkg::POS_W-1:0]   pos_o, start_o, lenp_o, lenq_o;
  logic [sts_pkg::DEPTH_W-1:0] dcur_o, dinc_o, ddec_o;

  // Between-tokens decision for the current byte
  logic             btw_emit;
  sts_pkg::result_t btw_res;
  logic [1:0]       btw_mode;
  logic [DW-1:0]    btw_depth;
  logic             btw_top;
  logic             btw_err;
  logic             btw_start;

  logic is_bracket;

  function automatic sts_pkg::result_t mk_res(
    input logic [sts_pkg::KIND_W-1:0]  kind,
    input logic [sts_pkg::ERR_W-1:0]   code,
    input logic [sts_pkg::POS_W-1:0]   pos,
    input logic [sts_pkg::LEN_W-1:0]   len,
    input logic                        quoted,
    input logic [sts_pkg::DEPTH_W-1:0] dep
  );
    sts_pkg::result_t r;
    r.event_kind  = kind;
    r.error_code  = code;
    r.position    = pos;
    r.atom_length = len;
    r.is_quoted   = quoted;
    r.depth       = dep;
    r.last        = 1'b0;
    return r;
  endfunction

  // Format positions, lengths and depths to the result widths
  assign len_plain  = pos_r - start_r;
  assign len_quoted = (len_plain != '0) ? (len_plain - PB'(1)) : '0;
  assign pos_x   = PXW'(pos_r);
  assign start_x = PXW'(start_r);
  assign lenp_x  = PXW'(len_plain);
  assign lenq_x  = PXW'(len_quoted);
  assign pos_o   = pos_x[sts_pkg::POS_W-1:0];
  assign start_o = start_x[sts_pkg::POS_W-1:0];
  assign lenp_o  = lenp_x[sts_pkg::LEN_W-1:0];
  assign lenq_o  = lenq_x[sts_pkg::LEN_W-1:0];
  assign dcur_x  = DXW'(depth_r);
  assign dinc_x  = DXW'(depth_r + DW'(1));
  assign ddec_x  = DXW'(depth_r - DW'(1));
  assign dcur_o  = dcur_x[sts_pkg::DEPTH_W-1:0];
  assign dinc_o  = dinc_x[sts_pkg::DEPTH_W-1:0];
  assign ddec_o  = ddec_x[sts_pkg::DEPTH_W-1:0];

  assign is_bracket = (data_byte == sts_pkg::CH_OPEN) || (data_byte == sts_pkg::CH_CLOSE);

  // Decide what a byte does between tokens
  always_comb begin
    btw_emit  = 1'b0;
    btw_res   = mk_res(sts_pkg::EV_OPEN, sts_pkg::ERR_NONE, pos_o, '0, 1'b0, dcur_o);
    btw_mode  = sts_pkg::MODE_BETWEEN;
    btw_depth = depth_r;
    btw_top   = top_r;
    btw_err   = 1'b0;
    btw_start = 1'b0;
    if (sts_pkg::is_ws(data_byte)) begin
      btw_mode = sts_pkg::MODE_BETWEEN;
    end else if (data_byte == sts_pkg::CH_SEMI) begin
      btw_mode = sts_pkg::MODE_COMMENT;
    end else if (data_byte == sts_pkg::CH_OPEN) begin
      btw_emit = 1'b1;
      if (depth_r >= DW'(MAX_DEPTH)) begin
        btw_res = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_TOO_DEEP, pos_o, '0, 1'b0, dcur_o);
        btw_err = 1'b1;
      end else if ((depth_r <= DW'(1)) && top_r) begin
        btw_res = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_SECOND_TOP, pos_o, '0, 1'b0, dcur_o);
        btw_err = 1'b1;
      end else begin
        if (depth_r <= DW'(1)) begin
          btw_top = 1'b1;
        end
        btw_depth = depth_r + DW'(1);
        btw_res   = mk_res(sts_pkg::EV_OPEN, sts_pkg::ERR_NONE, pos_o, '0, 1'b0, dinc_o);
      end
    end else if (data_byte == sts_pkg::CH_CLOSE) begin
      btw_emit = 1'b1;
      if (depth_r <= DW'(1)) begin
        btw_res = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_STRAY_CLOSE, pos_o, '0, 1'b0,
                         dcur_o);
        btw_err = 1'b1;
      end else begin
        btw_depth = depth_r - DW'(1);
        btw_res   = mk_res(sts_pkg::EV_CLOSE, sts_pkg::ERR_NONE, pos_o, '0, 1'b0, ddec_o);
      end
    end else begin
      if (depth_r <= DW'(1)) begin
        btw_emit = 1'b1;
        btw_res  = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_TOP_ATOM, pos_o, '0, 1'b0, dcur_o);
        btw_err  = 1'b1;
      end else begin
        btw_start = 1'b1;
        btw_mode  = (data_byte == sts_pkg::CH_QUOTE) ? sts_pkg::MODE_QUOTED
                                                     : sts_pkg::MODE_PLAIN;
      end
    end
  end

  // Next state and results for the accepted item
  always_comb begin
    sts_pkg::result_t term;
    mode_nxt    = mode_r;
    depth_nxt   = depth_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    top_nxt     = top_r;
    err_nxt     = err_r;
    push.cnt    = 2'd0;
    push.first  = btw_res;
    push.second = btw_res;
    term        = mk_res(sts_pkg::EV_DONE, sts_pkg::ERR_NONE, pos_o, '0, 1'b0, dcur_o);

    if (fire) begin
      if (action == sts_pkg::ACT_END) begin
        // Unless an error has halted the scan, flush the pending token and report the end; then reset
        if (!err_r) begin
          if (mode_r == sts_pkg::MODE_QUOTED) begin
            term = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_OPEN_QUOTE, pos_o, '0, 1'b0, dcur_o);
          end else if (depth_r > DW'(1)) begin
            term = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_MISS_CLOSE, pos_o, '0, 1'b0, dcur_o);
          end
          if (mode_r == sts_pkg::MODE_PLAIN) begin
            push.first  = mk_res(sts_pkg::EV_ATOM, sts_pkg::ERR_NONE, start_o, lenp_o, 1'b0,
                                 dcur_o);
            push.second = term;
            push.cnt    = 2'd2;
          end else begin
            push.first = term;
            push.cnt   = 2'd1;
          end
        end
        mode_nxt  = sts_pkg::MODE_BETWEEN;
        depth_nxt = DW'(1);
        pos_nxt   = '0;
        start_nxt = '0;
        top_nxt   = 1'b0;
        err_nxt   = 1'b0;
      end else begin
        if (!err_r) begin
          case (mode_r)
            sts_pkg::MODE_COMMENT: begin
              if (data_byte == sts_pkg::CH_LF) begin
                mode_nxt = sts_pkg::MODE_BETWEEN;
              end
            end
            sts_pkg::MODE_QUOTED: begin
              if (data_byte == sts_pkg::CH_QUOTE) begin
                push.first = mk_res(sts_pkg::EV_ATOM, sts_pkg::ERR_NONE, start_o, lenq_o,
                                    1'b1, dcur_o);
                push.cnt   = 2'd1;
                mode_nxt   = sts_pkg::MODE_BETWEEN;
              end
            end
            sts_pkg::MODE_PLAIN: begin
              if (data_byte == sts_pkg::CH_QUOTE) begin
                push.first = mk_res(sts_pkg::EV_ERROR, sts_pkg::ERR_QUOTE_ATOM, pos_o, '0,
                                    1'b0, dcur_o);
                push.cnt   = 2'd1;
                err_nxt    = 1'b1;
              end else if (sts_pkg::is_ws(data_byte) || is_bracket) begin
                // End the atom; a bracket then acts as between tokens
                push.first  = mk_res(sts_pkg::EV_ATOM, sts_pkg::ERR_NONE, start_o, lenp_o,
                                     1'b0, dcur_o);
                push.second = btw_res;
                push.cnt    = btw_emit ? 2'd2 : 2'd1;
                mode_nxt    = btw_mode;
                depth_nxt   = btw_depth;
                top_nxt     = btw_top;
                err_nxt     = btw_err;
              end
            end
            default: begin
              push.first = btw_res;
              push.cnt   = btw_emit ? 2'd1 : 2'd0;
              mode_nxt   = btw_mode;
              depth_nxt  = btw_depth;
              top_nxt    = btw_top;
              err_nxt    = btw_err;
              if (btw_start) begin
                start_nxt = pos_r;
              end
            end
          endcase
        end
        // Advance the byte position, saturating
        if (pos_r != '1) begin
          pos_nxt = pos_r + PB'(1);
        end
      end
    end

    // Mark the final result of this item
    if (push.cnt == 2'd1) begin
      push.first.last = 1'b1;
    end
    if (push.cnt == 2'd2) begin
      push.second.last = 1'b1;
    end
  end

  // Hold lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sts_pkg::MODE_BETWEEN;
      depth_r <= DW'(1);
      pos_r   <= '0;
      start_r <= '0;
      top_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      top_r   <= top_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ hw/rtl/sts_result_fifo.sv @@
// Small result queue that takes up to two results per cycle and hands out one when out_stall is low.
module sts_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  sts_pkg::push_t   push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_stall,
  output sts_pkg::result_t out_res
);

  localparam int AW = sts_pkg::FIFO_AW;

  sts_pkg::result_t mem [sts_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = mem[rd_r];
  assign room2     = (cnt_r <= (AW + 1)'(sts_pkg::FIFO_DEPTH - 2));

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = wr_r + AW'(push.cnt);
    rd_nxt  = pop ? (rd_r + AW'(1)) : rd_r;
    cnt_nxt = cnt_r + (AW + 1)'(push.cnt) - (AW + 1)'(pop);
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_r + AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/sexpr_token_scanner_core.sv @@
// Top level of the byte-serial S-expression token scanner.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------
//   in_      | input     | in_valid / in_stall  | action, data_byte
//   out_     | output    | out_valid / out_stall| event_kind, error_code, position,
//            |           |                      | atom_length, is_quoted, depth, last
//
// One byte is taken per cycle while in_stall is low; the lexer state registers update on
// the transfer and its results enter a four-entry result queue in the same edge.
// A result is written into the queue on its byte's transfer and is offered once it reaches the head;
// an item with two results (atom ended by a bracket, or atom flushed at end of input) drains one at a time.
// in_stall rises while the queue has room for fewer than two results.
// Synchronous reset returns the lexer to between tokens at depth 1 and empties the queue.
module sexpr_token_scanner_core #(
  parameter int MAX_DEPTH     = sts_pkg::MAX_DEPTH_DEF,
  parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sts_pkg::KIND_W-1:0]      out_event_kind,
  output logic [sts_pkg::ERR_W-1:0]       out_error_code,
  output logic [sts_pkg::POS_W-1:0]       out_position,
  output logic [sts_pkg::LEN_W-1:0]       out_atom_length,
  output logic                            out_is_quoted,
  output logic [sts_pkg::DEPTH_W-1:0]     out_depth,
  output logic                            out_last
);

  sts_pkg::push_t   push;
  sts_pkg::result_t res;
  logic             room2;
  logic             in_fire;

  // Accept a transfer while two result slots are free
  assign in_stall = !room2;
  assign in_fire  = in_valid && room2;

  sts_lexer #(
    .MAX_DEPTH     (MAX_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .action    (in_action),
    .data_byte (in_data_byte),
    .push      (push)
  );

  sts_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Unpack the head result
  assign out_event_kind  = res.event_kind;
  assign out_error_code  = res.error_code;
  assign out_position    = res.position;
  assign out_atom_length = res.atom_length;
  assign out_is_quoted   = res.is_quoted;
  assign out_depth       = res.depth;
  assign out_last        = res.last;

endmodule

@@ dv/sexpr_token_scanner_checker.sv @@
// Scoreboard for the S-expression token scanner: predicts events per byte transfer and checks them.
module sexpr_token_scanner_checker
  import sts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_data_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [KIND_W-1:0]  out_event_kind,
  input  logic [ERR_W-1:0]   out_error_code,
  input  logic [POS_W-1:0]   out_position,
  input  logic [LEN_W-1:0]   out_atom_length,
  input  logic               out_is_quoted,
  input  logic [DEPTH_W-1:0] out_depth,
  input  logic               out_last,
  output int                 mismatches,
  output int                 awaiting,
  output int                 scanned
);

  localparam int PB = POSITION_BITS_DEF;

  // Lexer state mirrored from the byte stream
  logic [1:0]    lex_mode;
  int            nesting;
  logic [PB-1:0] scan_pos;
  logic [PB-1:0] tok_start;
  bit            list_opened;
  bit            halted;

  result_t step_events[$];
  result_t expected_events[$];

  function automatic bit blank_char(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic void clear_scan();
    lex_mode    = MODE_BETWEEN;
    nesting     = 1;
    scan_pos    = '0;
    tok_start   = '0;
    list_opened = 1'b0;
    halted      = 1'b0;
  endfunction

  function automatic void record(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] code,
                                 logic [PB-1:0] pos, logic [PB-1:0] len, logic quoted);
    result_t r;
    r.event_kind  = kind;
    r.error_code  = code;
    r.position    = POS_W'(pos);
    r.atom_length = LEN_W'(len);
    r.is_quoted   = quoted;
    r.depth       = DEPTH_W'(nesting);
    r.last        = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void raise_error(logic [ERR_W-1:0] code, logic [PB-1:0] pos);
    record(EV_ERROR, code, pos, '0, 1'b0);
    halted = 1'b1;
  endfunction

  // Handle a byte seen between tokens
  function automatic void scan_token_start(logic [7:0] c);
    if (blank_char(c)) begin
      return;
    end else if (c == CH_SEMI) begin
      lex_mode = MODE_COMMENT;
    end else if (c == CH_OPEN) begin
      if (nesting >= MAX_DEPTH_DEF) begin
        raise_error(ERR_TOO_DEEP, scan_pos);
      end else if (nesting <= 1 && list_opened) begin
        raise_error(ERR_SECOND_TOP, scan_pos);
      end else begin
        if (nesting <= 1) list_opened = 1'b1;
        nesting++;
        record(EV_OPEN, ERR_NONE, scan_pos, '0, 1'b0);
      end
    end else if (c == CH_CLOSE) begin
      if (nesting <= 1) begin
        raise_error(ERR_STRAY_CLOSE, scan_pos);
      end else begin
        nesting--;
        record(EV_CLOSE, ERR_NONE, scan_pos, '0, 1'b0);
      end
    end else if (nesting <= 1) begin
      raise_error(ERR_TOP_ATOM, scan_pos);
    end else begin
      tok_start = scan_pos;
      lex_mode  = (c == CH_QUOTE) ? MODE_QUOTED : MODE_PLAIN;
    end
  endfunction

  // Work out the events caused by one input transfer
  function automatic void predict_item(logic act, logic [7:0] c);
    logic [PB-1:0] span;
    step_events.delete();
    scanned++;
    if (act == ACT_END) begin
      if (!halted) begin
        if (lex_mode == MODE_PLAIN)
          record(EV_ATOM, ERR_NONE, tok_start, scan_pos - tok_start, 1'b0);
        if (lex_mode == MODE_QUOTED)
          record(EV_ERROR, ERR_OPEN_QUOTE, scan_pos, '0, 1'b0);
        else if (nesting > 1)
          record(EV_ERROR, ERR_MISS_CLOSE, scan_pos, '0, 1'b0);
        else
          record(EV_DONE, ERR_NONE, scan_pos, '0, 1'b0);
      end
      clear_scan();
    end else begin
      if (!halted) begin
        case (lex_mode)
          MODE_COMMENT: begin
            if (c == CH_LF) lex_mode = MODE_BETWEEN;
          end
          MODE_QUOTED: begin
            if (c == CH_QUOTE) begin
              // length excludes both quotes
              span = scan_pos - tok_start;
              record(EV_ATOM, ERR_NONE, tok_start, (span != '0) ? span - PB'(1) : span, 1'b1);
              lex_mode = MODE_BETWEEN;
            end
          end
          MODE_PLAIN: begin
            if (c == CH_QUOTE) begin
              raise_error(ERR_QUOTE_ATOM, scan_pos);
            end else if (blank_char(c) || c == CH_OPEN || c == CH_CLOSE) begin
              record(EV_ATOM, ERR_NONE, tok_start, scan_pos - tok_start, 1'b0);
              lex_mode = MODE_BETWEEN;
              if (c == CH_OPEN || c == CH_CLOSE) scan_token_start(c);
            end
          end
          default: scan_token_start(c);
        endcase
      end
      // Saturate the byte offset
      if (scan_pos != '1) scan_pos++;
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endfunction

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare one result transfer against the oldest expected event
  task automatic check_event();
    result_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected result: event_kind %0d position %0d", out_event_kind, out_position);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      compare_field("event_kind", want.event_kind, out_event_kind);
      compare_field("error_code", want.error_code, out_error_code);
      compare_field("position", want.position, out_position);
      compare_field("atom_length", want.atom_length, out_atom_length);
      compare_field("is_quoted", want.is_quoted, out_is_quoted);
      compare_field("depth", want.depth, out_depth);
      compare_field("last", want.last, out_last);
    end
  endtask

  // Check results first: a result never leaves on the edge that takes its byte
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_events.delete();
      mismatches = 0;
      scanned    = 0;
    end else begin
      if (out_valid && !out_stall) check_event();
      if (in_valid && !in_stall) predict_item(in_action, in_data_byte);
    end
    awaiting = expected_events.size();
  end

endmodule

@@ dv/sexpr_token_scanner_core_tb.sv @@
// Testbench top for the S-expression token scanner: byte-stream stimulus, idling and verdict.
module sexpr_token_scanner_core_tb;
  import sts_pkg::*;

  localparam int ITEM_GOAL   = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    logic       act;
    logic [7:0] b;
  } scan_item_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_stall;
  logic [KIND_W-1:0]  out_event_kind;
  logic [ERR_W-1:0]   out_error_code;
  logic [POS_W-1:0]   out_position;
  logic [LEN_W-1:0]   out_atom_length;
  logic               out_is_quoted;
  logic [DEPTH_W-1:0] out_depth;
  logic               out_last;

  int chk_fails;
  int chk_awaiting;
  int chk_scanned;
  int cycles;

  bit tx_burst;
  bit rx_burst;
  scan_item_t doc[$];

  sexpr_token_scanner_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_error_code  (out_error_code),
    .out_position    (out_position),
    .out_atom_length (out_atom_length),
    .out_is_quoted   (out_is_quoted),
    .out_depth       (out_depth),
    .out_last        (out_last)
  );

  sexpr_token_scanner_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_error_code  (out_error_code),
    .out_position    (out_position),
    .out_atom_length (out_atom_length),
    .out_is_quoted   (out_is_quoted),
    .out_depth       (out_depth),
    .out_last        (out_last),
    .mismatches      (chk_fails),
    .awaiting        (chk_awaiting),
    .scanned         (chk_scanned)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: raise out_stall for a random hold before each transfer, with no hold during bursts
  initial begin
    int hold;
    int taken;
    taken     = 0;
    rx_burst  = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      if (taken % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // ---------------------------------------------------------------- stream building
  task automatic add_byte(logic [7:0] c);
    doc.push_back('{ACT_DATA, c});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Any byte that may sit inside a plain atom; a leading ';' would open a comment
  function automatic logic [7:0] pick_atom_byte(bit lead);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_OPEN ||
               c == CH_CLOSE || c == CH_QUOTE || (lead && c == CH_SEMI));
    return c;
  endfunction

  task automatic put_blank();
    repeat ($urandom_range(1, 3)) add_byte(pick_blank());
  endtask

  task automatic put_comment();
    logic [7:0] c;
    add_byte(CH_SEMI);
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
      add_byte(c);
    end
    add_byte(CH_LF);
  endtask

  task automatic put_plain();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
    add_byte(pick_atom_byte(1'b1));
    repeat (n) add_byte(pick_atom_byte(1'b0));
  endtask

  task automatic put_quoted();
    logic [7:0] c;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
      add_byte(c);
    end
    add_byte(CH_QUOTE);
  endtask

  // Well-formed list; a plain atom needs a separator before anything but a bracket
  task automatic put_list(int lvl, int maxlvl);
    int  pick;
    bit  glued;
    add_byte(CH_OPEN);
    glued = 1'b0;
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 9);
      if (pick >= 8 && lvl < maxlvl) begin
        put_list(lvl + 1, maxlvl);
        glued = 1'b0;
      end else begin
        if (glued || $urandom_range(0, 3) == 0) put_blank();
        if (pick == 7) begin
          put_comment();
          glued = 1'b0;
        end else if (pick >= 5 && pick < 7) begin
          put_quoted();
          glued = 1'b0;
        end else begin
          put_plain();
          glued = 1'b1;
        end
      end
    end
    if (glued && $urandom_range(0, 1) == 1) put_blank();
    add_byte(CH_CLOSE);
  endtask

  // Nesting chain near the depth limit; the longest one overflows it
  task automatic put_deep();
    int n;
    n = $urandom_range(29, 32);
    repeat (n) begin
      add_byte(CH_OPEN);
      if ($urandom_range(0, 3) == 0) begin
        put_plain();
        put_blank();
      end
    end
    repeat (n) add_byte(CH_CLOSE);
  endtask

  task automatic build_doc();
    int         r;
    int         cut;
    scan_item_t extra;
    logic [7:0] specials[6];
    specials = '{CH_OPEN, CH_CLOSE, CH_QUOTE, CH_SEMI, CH_LF, 8'h00};
    doc.delete();
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) put_blank();
    if ($urandom_range(0, 4) == 0) put_comment();
    if (r < 60) begin
      put_list(1, $urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) put_blank();
      if ($urandom_range(0, 5) == 0) put_comment();
    end else if (r < 65) begin
      put_deep();
    end else if (r < 75) begin
      // truncate: leaves open lists, quotes, comments or a pending atom
      put_list(1, 3);
      cut = $urandom_range(0, doc.size());
      while (doc.size() > cut) void'(doc.pop_back());
    end else if (r < 85) begin
      put_list(1, 3);
      extra.act = ACT_DATA;
      extra.b   = specials[$urandom_range(0, 5)];
      if (extra.b == 8'h00) extra.b = 8'($urandom_range(0, 255));
      doc.insert($urandom_range(0, doc.size()), extra);
    end else if (r < 90) begin
      put_list(1, 2);
      if ($urandom_range(0, 1) == 1) put_blank();
      case ($urandom_range(0, 2))
        0:       add_byte(CH_OPEN);
        1:       add_byte(CH_CLOSE);
        default: put_plain();
      endcase
    end else if (r < 95) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    end
    // data_byte is don't-care on end of input: randomize it anyway
    doc.push_back('{ACT_END, 8'($urandom_range(0, 255))});
  endtask

  // ---------------------------------------------------------------- driving
  task automatic send_item(scan_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= it.act;
    in_data_byte <= it.b;
    // hold the payload until the transfer
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_item(doc[i]);
  endtask

  task automatic send_text_doc(string s);
    doc.delete();
    add_text(s);
    doc.push_back('{ACT_END, 8'h00});
    send_doc();
  endtask

  // Stop sending until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_awaiting != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_DATA;
    in_data_byte <= 8'h00;
    tx_burst     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stream, then each error kind except too-deep nesting, and atom/bracket pairs
    send_text_doc("");
    doc.delete();
    add_text("(a(\"\"");
    add_byte(8'hFF);
    add_byte(CH_CLOSE);
    doc.push_back('{ACT_END, 8'hFF});
    send_doc();
    send_text_doc(")");
    doc.delete();
    add_byte(8'h00);
    doc.push_back('{ACT_END, 8'h00});
    send_doc();
    send_text_doc("()(");
    send_text_doc("(\"a");
    send_text_doc("(b\"");
    drain();

    // Random documents, mostly well formed
    while (chk_scanned < ITEM_GOAL) begin
      build_doc();
      tx_burst = ($urandom_range(0, 3) == 0);
      send_doc();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (16) @(posedge clk);
    if (chk_fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
